### sv/tcpq_pkg.sv
// Shared types and codes for the two-class priority queue.
package tcpq_pkg;

  localparam int unsigned IdW = 16;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] entry_id;
    logic           is_urgent;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] out_id;
    logic           out_urgent;
  } rsp_t;

  typedef struct packed {
    logic           valid;
    logic           urgent;
    logic [IdW-1:0] id;
  } slot_t;

  typedef struct packed {
    logic           enq;
    logic           deq;
    logic           urgent;
    logic [IdW-1:0] id;
  } cell_cmd_t;

  localparam slot_t HEAD_SLOT = '{valid: 1'b1, urgent: 1'b1, id: '0};
  localparam slot_t EMPTY_SLOT = '{valid: 1'b0, urgent: 1'b0, id: '0};

endpackage

### sv/tcpq_cell.sv
// One queue position: holds a slot and trades it with its neighbors.
module tcpq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcpq_pkg::cell_cmd_t cmd_i,
  input  tcpq_pkg::slot_t   left_i,
  input  tcpq_pkg::slot_t   right_i,
  output tcpq_pkg::slot_t   slot_o
);
  import tcpq_pkg::*;

  logic           valid_q, valid_d;
  logic           urgent_q, urgent_d;
  logic [IdW-1:0] id_q, id_d;
  logic           load;
  slot_t          src;

  always_comb begin
    load = 1'b0;
    src  = left_i;
    if (cmd_i.deq) begin
      load = 1'b1;
      src  = right_i;
    end else if (cmd_i.enq) begin
      if (cmd_i.urgent) begin
        if (!(valid_q && urgent_q)) begin
          load = 1'b1;
          if (left_i.valid && left_i.urgent) begin
            src = '{valid: 1'b1, urgent: 1'b1, id: cmd_i.id};
          end else begin
            src = left_i;
          end
        end
      end else if (!valid_q && left_i.valid) begin
        load = 1'b1;
        src  = '{valid: 1'b1, urgent: 1'b0, id: cmd_i.id};
      end
    end
    valid_d  = load ? src.valid : valid_q;
    urgent_d = load ? src.urgent : urgent_q;
    id_d     = load ? src.id : id_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    urgent_q <= urgent_d;
    id_q     <= id_d;
  end

  assign slot_o = '{valid: valid_q, urgent: urgent_q, id: id_q};

endmodule

### sv/two_class_priority_queue.sv
// Two-class priority queue built as a row of cells ordered urgent first, then normal.
// The result is registered: it appears in the cycle after start is taken, on done for one cycle.
// Throughput: one item per cycle; busy stays low, and all cells update in the same cycle.
// Reset: clears every cell's occupancy and the result strobe; the queue is empty at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module two_class_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tcpq_pkg::req_t req_i,
  output logic           done_o,
  output tcpq_pkg::rsp_t rsp_o
);
  import tcpq_pkg::*;

  slot_t     slots [CAPACITY];
  cell_cmd_t cmd;
  logic      accept, full, empty;
  logic      done_q;
  rsp_t      rsp_q, rsp_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = slots[CAPACITY-1].valid;
  assign empty  = !slots[0].valid;

  always_comb begin
    cmd.enq    = accept && (req_i.kind == KIND_ENQ) && !full;
    cmd.deq    = accept && (req_i.kind == KIND_DEQ) && !empty;
    cmd.urgent = req_i.is_urgent;
    cmd.id     = req_i.entry_id;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left, right;
    if (i == 0) begin : g_head
      assign left = HEAD_SLOT;
    end else begin : g_mid
      assign left = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = EMPTY_SLOT;
    end else begin : g_body
      assign right = slots[i+1];
    end
    tcpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .slot_o (slots[i])
    );
  end

  always_comb begin
    rsp_d = '{status: ST_DONE, out_id: '0, out_urgent: 1'b0};
    if (req_i.kind == KIND_ENQ) begin
      if (full) begin
        rsp_d.status = ST_FULL;
      end
    end else if (empty) begin
      rsp_d.status = ST_EMPTY;
    end else begin
      rsp_d.out_id     = slots[0].id;
      rsp_d.out_urgent = slots[0].urgent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the two-class priority queue: directed, fill/drain and random items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  localparam int unsigned QueueDepth = 16;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  two_class_priority_queue #(
    .CAPACITY(QueueDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  logic [IdW-1:0] urgent_ids[$];
  logic [IdW-1:0] normal_ids[$];
  rsp_t           pending_rsps[$];

  int unsigned idle_pct;
  int unsigned n_errors;
  int unsigned n_stored;
  int unsigned n_refused;
  int unsigned n_empty;
  int unsigned n_urgent_out;
  int unsigned n_normal_out;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200us;
    $display("TEST FAILED");
    $finish;
  end

  function automatic rsp_t serve_request(req_t r);
    rsp_t rsp;
    rsp = '0;
    rsp.status = ST_DONE;
    if (r.kind == KIND_ENQ) begin
      if (urgent_ids.size() + normal_ids.size() >= QueueDepth) begin
        rsp.status = ST_FULL;
      end else if (r.is_urgent) begin
        urgent_ids.push_back(r.entry_id);
      end else begin
        normal_ids.push_back(r.entry_id);
      end
    end else if (urgent_ids.size() > 0) begin
      rsp.out_id     = urgent_ids.pop_front();
      rsp.out_urgent = 1'b1;
    end else if (normal_ids.size() > 0) begin
      rsp.out_id = normal_ids.pop_front();
    end else begin
      rsp.status = ST_EMPTY;
    end
    return rsp;
  endfunction

  function automatic req_t enq_req(logic urgent, logic [IdW-1:0] id);
    req_t r;
    r.kind      = KIND_ENQ;
    r.entry_id  = id;
    r.is_urgent = urgent;
    return r;
  endfunction

  function automatic req_t deq_req();
    req_t r;
    r.kind      = KIND_DEQ;
    r.entry_id  = IdW'($urandom_range(16'hFFFF));
    r.is_urgent = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (pending_rsps.size() == 0) begin
      report_mismatch("item with none pending", 32'(got), 32'd0);
      return;
    end
    want = pending_rsps.pop_front();
    if (got.status !== want.status) begin
      report_mismatch("status", 32'(got.status), 32'(want.status));
    end
    if (got.out_id !== want.out_id) begin
      report_mismatch("out_id", 32'(got.out_id), 32'(want.out_id));
    end
    if (got.out_urgent !== want.out_urgent) begin
      report_mismatch("out_urgent", 32'(got.out_urgent), 32'(want.out_urgent));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) check_result(rsp_o);
  end

  // Called right after a falling edge; returns after the falling edge that follows acceptance.
  task automatic send_item(req_t item);
    logic [31:0] noise;
    rsp_t        want;
    while ($urandom_range(99) < idle_pct) begin
      noise = $urandom;
      start <= 1'b0;
      req_i <= noise[$bits(req_t)-1:0];
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    want = serve_request(item);
    pending_rsps.push_back(want);
    case (want.status)
      ST_FULL:  n_refused++;
      ST_EMPTY: n_empty++;
      default: begin
        if (item.kind == KIND_ENQ) n_stored++;
        else if (want.out_urgent) n_urgent_out++;
        else n_normal_out++;
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    req_i <= '0;
    do @(negedge clk_i); while (pending_rsps.size() > 0);
  endtask

  task automatic test_directed();
    send_item(deq_req());
    send_item(enq_req(1'b0, 16'hFFFF));
    send_item(enq_req(1'b1, 16'h0000));
    send_item(enq_req(1'b0, 16'h0001));
    send_item(enq_req(1'b1, 16'h8000));
    repeat (4) send_item(deq_req());
    send_item(deq_req());
    send_item(enq_req(1'b1, 16'hFFFF));
    send_item(enq_req(1'b0, 16'h5555));
    send_item(enq_req(1'b1, 16'hAAAA));
    repeat (3) send_item(deq_req());
  endtask

  task automatic test_fill_and_drain(int unsigned rounds);
    int unsigned urg_pct;
    for (int unsigned r = 0; r < rounds; r++) begin
      urg_pct = (r == 0) ? 100 : (r == 1) ? 0 : 50;
      repeat (QueueDepth) begin
        send_item(enq_req($urandom_range(99) < urg_pct, IdW'($urandom_range(16'hFFFF))));
      end
      send_item(enq_req(1'b1, IdW'($urandom_range(16'hFFFF))));
      send_item(enq_req(1'b0, IdW'($urandom_range(16'hFFFF))));
      send_item(deq_req());
      send_item(enq_req(1'b0, 16'hFFFF));
      send_item(enq_req(1'b1, 16'h0000));
      repeat (QueueDepth + 1) send_item(deq_req());
    end
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned enq_pct;
    int unsigned urg_pct;
    enq_pct = 50;
    urg_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 90;
          1:       enq_pct = 50;
          default: enq_pct = 10;
        endcase
        urg_pct = $urandom_range(100);
      end
      if ($urandom_range(99) < enq_pct) begin
        send_item(enq_req($urandom_range(99) < urg_pct, IdW'($urandom_range(16'hFFFF))));
      end else begin
        send_item(deq_req());
      end
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    idle_pct = 33;
    n_errors = 0;
    n_stored = 0;
    n_refused = 0;
    n_empty = 0;
    n_urgent_out = 0;
    n_normal_out = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    pause_until_drained();
    test_fill_and_drain(3);
    idle_pct = 0;
    test_random_mix(700);
    idle_pct = 33;
    pause_until_drained();
    test_random_mix(1100);

    pause_until_drained();
    repeat (4) @(negedge clk_i);

    $display("Covered %0d stored entries, %0d refused on full, %0d empty dequeues,",
             n_stored, n_refused, n_empty);
    $display("and %0d urgent plus %0d normal entries served, with %0d mismatches.",
             n_urgent_out, n_normal_out, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
